>>> sv/vpl_pkg.sv
// vertex phong lighting: shared widths, fixed point constants, types and helpers
// used by vpl_norm and vertex_phong_lighting_top, depends on nothing
package vpl_pkg;

	localparam int VAL_W     = 16;
	localparam int FRAC_BITS = 14;
	localparam int EXP_BITS  = 8;
	localparam int ACC_W     = 40;
	localparam int PROD_W    = 2 * VAL_W;

	// normalize: len = isqrt(len2 << 16), q = c * 2^NORM_SH / len
	localparam int LEN2_W    = 2 * VAL_W;
	localparam int NORM_SH   = FRAC_BITS + 8;
	localparam int RAD_W     = LEN2_W + 16;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int SQ_STEPS  = ROOT_W / 2;
	localparam int QUO_W     = VAL_W;
	localparam int DVD_W     = VAL_W + NORM_SH;
	localparam int DIV_STEPS = QUO_W / 2;

	localparam int ONE_Q     = 1 << FRAC_BITS;
	localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
	localparam int AMBIENT_Q = (ONE_Q + 5) / 10;
	localparam int KD_Q      = (9 * ONE_Q + 5) / 10;
	localparam int KS_Q      = ONE_Q / 2;
	localparam int UNIT_LIM  = ONE_Q + ONE_Q / 256 + 2;

	localparam int PW_N      = 2 * EXP_BITS;

	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int LIGHT_W   = 48;
	localparam int IN_W      = 112;
	localparam int OUT_W     = 72;
	localparam int INTEN_W   = 15;

	// input item bit offsets
	localparam int IN_POS    = 2;
	localparam int IN_NRM    = 50;
	localparam int IN_SHIN   = 98;

	localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] ACC_MIN  = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF_Q);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MV_X,
		REG_MV_Y,
		REG_MV_Z,
		REG_NR_X,
		REG_NR_Y,
		REG_NR_Z,
		REG_LIGHT
	} reg_idx_t;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef val_t [2:0]               vec3_t;

	typedef struct packed {
		logic [1:0]          corner;
		logic [EXP_BITS-1:0] shin;
		vec3_t               cam;
	} tag_t;

	typedef struct packed {
		tag_t  tag;
		vec3_t v;
		val_t  diff;
	} side2_t;

	function automatic val_t sat16(input logic signed [ACC_W-1:0] a);
		val_t r;
		if (a > ACC_MAX)
			r = ACC_MAX[VAL_W-1:0];
		else if (a < ACC_MIN)
			r = ACC_MIN[VAL_W-1:0];
		else
			r = a[VAL_W-1:0];
		return r;
	endfunction

	// round half up, then floor
	function automatic logic signed [ACC_W-1:0] rnd_q(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t;
		t = a + ACC_HALF;
		return t >>> FRAC_BITS;
	endfunction

	function automatic val_t mulq(input val_t a, input val_t b);
		prod_t p;
		p = a * b;
		return sat16(rnd_q(ACC_W'(p)));
	endfunction

	function automatic val_t lane(input logic [CFG_W-1:0] r, input int k);
		return val_t'(r[VAL_W*k +: VAL_W]);
	endfunction

endpackage

>>> sv/vertex_phong_lighting_top.sv
// vertex phong lighting top: transform, two normalize units, diffuse and
// specular terms, power chain, output register; uses vpl_pkg and vpl_norm
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: vertex item (112 bits)
//  m_*       out  m_tvalid/m_tready  m_tdata: lit vertex item (72 bits)
//  cfg_*     in   cfg_we             cfg_idx, cfg_data: matrix rows and light
//
//  one item per cycle sustained while the output register is not stalled
//  the pipe depth lies mostly in the two normalize units (23 stages each, square root and
//  divide at two bits per stage) and the 16-stage square-and-multiply chain
//  arst_n clears all valid bits and loads identity rows and light (0,0,1)
//  the whole pipe holds when the output register is full and m_tready is low
module vertex_phong_lighting_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// corner, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, shininess
	input  logic [vpl_pkg::IN_W-1:0]          s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// corner_out, intensity, cam_x, cam_y, cam_z
	output logic [vpl_pkg::OUT_W-1:0]         m_tdata,
	input  logic                              cfg_we,
	input  logic [vpl_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [vpl_pkg::CFG_W-1:0]         cfg_data
);
	import vpl_pkg::*;

	localparam int SIDE1_W = $bits(tag_t);
	localparam int SIDE2_W = $bits(side2_t);

	logic [CFG_W-1:0]   mv_q [3];
	logic [CFG_W-1:0]   nr_q [3];
	logic [LIGHT_W-1:0] light_q;

	logic  adv;
	vec3_t lvec;
	vec3_t pin;
	vec3_t nin;

	// stage registers
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s9, vld_s10;
	tag_t  tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s9, tag_s10;
	prod_t pp_s1 [3][3];
	prod_t np_s1 [3][3];
	vec3_t cam_s2, nc_s2, vv_s2;
	prod_t nl_s3 [3];
	vec3_t n_s3, n_s4;
	vec3_t v_s3, v_s4, v_s5, v_s6;
	val_t  d_s4, d_s5;
	prod_t nd_s5 [3];
	vec3_t rr_s6;
	val_t  diff_s6, diff_s7;
	prod_t rv_s7 [3];

	logic  vld_pw_s  [0:PW_N];
	tag_t  tag_pw_s  [0:PW_N];
	val_t  spec_pw_s [0:PW_N];
	val_t  rv_pw_s   [0:PW_N];
	val_t  diff_pw_s [0:PW_N];

	val_t  kd_s9, ks_s9;
	logic [INTEN_W-1:0] inten_s10;

	// normalize units
	logic             n1_vld;
	vec3_t [1:0]      n1_vec;
	logic [SIDE1_W-1:0] n1_side;
	tag_t             n1_tag;
	logic             n2_vld;
	vec3_t [0:0]      n2_vec;
	logic [SIDE2_W-1:0] n2_side;
	side2_t           n2_sd;
	side2_t           s2_sd;

	// combinational
	vec3_t cam_c, nc_c, vv_c, rr_c;
	val_t  d_c, rv_c, diff_c;
	logic signed [VAL_W+1:0] inten_c;

	assign adv      = !vld_s10 || m_tready;
	assign s_tready = adv;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lvec[i] = val_t'(light_q[VAL_W*i +: VAL_W]);
			pin[i]  = val_t'(s_tdata[IN_POS + VAL_W*i +: VAL_W]);
			nin[i]  = val_t'(s_tdata[IN_NRM + VAL_W*i +: VAL_W]);
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q[0] <= CFG_W'(64'h0000_0000_0000_4000);
			mv_q[1] <= CFG_W'(64'h0000_0000_4000_0000);
			mv_q[2] <= CFG_W'(64'h0000_4000_0000_0000);
			nr_q[0] <= CFG_W'(64'h0000_0000_0000_4000);
			nr_q[1] <= CFG_W'(64'h0000_0000_4000_0000);
			nr_q[2] <= CFG_W'(64'h0000_4000_0000_0000);
			light_q <= LIGHT_W'(48'h4000_0000_0000);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MV_X:  mv_q[0] <= cfg_data;
				REG_MV_Y:  mv_q[1] <= cfg_data;
				REG_MV_Z:  mv_q[2] <= cfg_data;
				REG_NR_X:  nr_q[0] <= cfg_data;
				REG_NR_Y:  nr_q[1] <= cfg_data;
				REG_NR_Z:  nr_q[2] <= cfg_data;
				REG_LIGHT: light_q <= cfg_data[LIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cam_c[i] = sat16(rnd_q(ACC_W'(pp_s1[i][0]) + ACC_W'(pp_s1[i][1]) +
				ACC_W'(pp_s1[i][2]) + (ACC_W'(lane(mv_q[i], 3)) <<< FRAC_BITS)));
			nc_c[i]  = sat16(rnd_q(ACC_W'(np_s1[i][0]) + ACC_W'(np_s1[i][1]) +
				ACC_W'(np_s1[i][2])));
			vv_c[i]  = sat16(-ACC_W'(cam_c[i]));
			rr_c[i]  = sat16(ACC_W'(sat16(rnd_q(ACC_W'(nd_s5[i]) <<< 1))) - ACC_W'(lvec[i]));
		end
		d_c    = sat16(rnd_q(ACC_W'(nl_s3[0]) + ACC_W'(nl_s3[1]) + ACC_W'(nl_s3[2])));
		diff_c = d_s5[VAL_W-1] ? val_t'(0) : d_s5;
		rv_c   = sat16(rnd_q(ACC_W'(rv_s7[0]) + ACC_W'(rv_s7[1]) + ACC_W'(rv_s7[2])));
		if (rv_c[VAL_W-1])
			rv_c = '0;
		inten_c = (VAL_W+2)'(AMBIENT_Q) + (VAL_W+2)'(kd_s9) + (VAL_W+2)'(ks_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			for (int k = 0; k <= PW_N; k++)
				vld_pw_s[k] <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= n1_vld;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= n2_vld;
			vld_pw_s[0] <= vld_s7;
			for (int k = 1; k <= PW_N; k++)
				vld_pw_s[k] <= vld_pw_s[k-1];
			vld_s9  <= vld_pw_s[PW_N];
			vld_s10 <= vld_s9;
		end
	end

	assign n1_tag = tag_t'(n1_side);
	assign n2_sd  = side2_t'(n2_side);

	always_comb begin
		s2_sd.tag  = tag_s6;
		s2_sd.v    = v_s6;
		s2_sd.diff = diff_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// transform products
			tag_s1.corner <= s_tdata[1:0];
			tag_s1.shin   <= s_tdata[IN_SHIN +: EXP_BITS];
			tag_s1.cam    <= '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					pp_s1[i][j] <= lane(mv_q[i], j) * pin[j];
					np_s1[i][j] <= lane(nr_q[i], j) * nin[j];
				end
			// camera position, normal, view vector
			tag_s2.corner <= tag_s1.corner;
			tag_s2.shin   <= tag_s1.shin;
			tag_s2.cam    <= cam_c;
			cam_s2 <= cam_c;
			nc_s2  <= nc_c;
			vv_s2  <= vv_c;
			// n.l products
			tag_s3 <= n1_tag;
			n_s3   <= n1_vec[0];
			v_s3   <= n1_vec[1];
			for (int i = 0; i < 3; i++)
				nl_s3[i] <= n1_vec[0][i] * lvec[i];
			tag_s4 <= tag_s3;
			n_s4   <= n_s3;
			v_s4   <= v_s3;
			d_s4   <= d_c;
			// reflection
			tag_s5 <= tag_s4;
			v_s5   <= v_s4;
			d_s5   <= d_s4;
			for (int i = 0; i < 3; i++)
				nd_s5[i] <= n_s4[i] * d_s4;
			tag_s6  <= tag_s5;
			v_s6    <= v_s5;
			diff_s6 <= diff_c;
			rr_s6   <= rr_c;
			// r.v
			tag_s7  <= n2_sd.tag;
			diff_s7 <= n2_sd.diff;
			for (int i = 0; i < 3; i++)
				rv_s7[i] <= n2_vec[0][i] * n2_sd.v[i];
			tag_pw_s[0]  <= tag_s7;
			diff_pw_s[0] <= diff_s7;
			rv_pw_s[0]   <= rv_c;
			spec_pw_s[0] <= val_t'(ONE_Q);
			// square and multiply, top exponent bit first
			for (int j = 0; j < PW_N; j++) begin
				tag_pw_s[j+1]  <= tag_pw_s[j];
				rv_pw_s[j+1]   <= rv_pw_s[j];
				diff_pw_s[j+1] <= diff_pw_s[j];
				if (j % 2 == 0)
					spec_pw_s[j+1] <= mulq(spec_pw_s[j], spec_pw_s[j]);
				else if (tag_pw_s[j].shin[EXP_BITS - 1 - j / 2])
					spec_pw_s[j+1] <= mulq(spec_pw_s[j], rv_pw_s[j]);
				else
					spec_pw_s[j+1] <= spec_pw_s[j];
			end
			// weighted terms
			tag_s9  <= tag_pw_s[PW_N];
			kd_s9   <= mulq(val_t'(KD_Q), diff_pw_s[PW_N]);
			ks_s9   <= mulq(val_t'(KS_Q), spec_pw_s[PW_N]);
			// output register
			tag_s10 <= tag_s9;
			if (inten_c > (VAL_W+2)'(32767))
				inten_s10 <= '1;
			else if (inten_c < 0)
				inten_s10 <= '0;
			else
				inten_s10 <= inten_c[INTEN_W-1:0];
		end
	end

	vpl_norm #(
		.NVEC   (2),
		.SIDE_W (SIDE1_W)
	) u_norm_nv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s2),
		.in_vec   ({vv_s2, nc_s2}),
		.in_side  (SIDE1_W'(tag_s2)),
		.out_vld  (n1_vld),
		.out_vec  (n1_vec),
		.out_side (n1_side)
	);

	vpl_norm #(
		.NVEC   (1),
		.SIDE_W (SIDE2_W)
	) u_norm_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s6),
		.in_vec   (rr_s6),
		.in_side  (SIDE2_W'(s2_sd)),
		.out_vld  (n2_vld),
		.out_vec  (n2_vec),
		.out_side (n2_side)
	);

	assign m_tvalid = vld_s10;
	assign m_tdata  = {7'b0, tag_s10.cam[2], tag_s10.cam[1], tag_s10.cam[0], inten_s10,
		tag_s10.corner};

	a_inten_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 |-> (inten_s10 >= INTEN_W'(AMBIENT_Q)))
		else $error("intensity below ambient");

	a_rv_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_pw_s[0] |-> !rv_pw_s[0][VAL_W-1])
		else $error("specular base negative");

	a_diff_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> !diff_s6[VAL_W-1])
		else $error("diffuse term negative");

	a_cam_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s2) |=> (tag_s2 == $past(tag_s2)) || !$past(adv) || (tag_s2.cam == cam_s2))
		else $error("camera position lost from item tag");

endmodule

>>> sv/vpl_norm.sv
// vertex phong lighting: pipelined vector normalize (squares, 2-bit/stage
// square root, 2-bit/stage restoring divide); uses vpl_pkg
module vpl_norm #(
	parameter int NVEC   = 1,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  vpl_pkg::vec3_t [NVEC-1:0]     in_vec,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output vpl_pkg::vec3_t [NVEC-1:0]     out_vec,
	output logic [SIDE_W-1:0]             out_side
);
	import vpl_pkg::*;

	localparam int NS = SQ_STEPS;
	localparam int ND = DIV_STEPS;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [LEN2_W-1:0] rad;
	} sq_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [QUO_W-1:0]  low;
		logic [QUO_W-1:0]  quo;
	} dv_t;

	function automatic logic [LEN2_W-1:0] sq_val(input val_t a);
		prod_t p;
		p = a * a;
		return LEN2_W'(unsigned'(p));
	endfunction

	function automatic sq_t sq_step(input sq_t a);
		sq_t r;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		t      = {a.rem[REM_W-3:0], a.rad[LEN2_W-1 -: 2]};
		trial  = {1'b0, a.root, 2'b01};
		r.rad  = a.rad << 2;
		if (t >= trial) begin
			r.rem  = t - trial;
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = t;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic dv_t dv_init(input val_t c, input logic [ROOT_W-1:0] len);
		dv_t r;
		logic [VAL_W-1:0] mag;
		logic [DVD_W-1:0] dvd;
		mag   = c[VAL_W-1] ? (~c + 1'b1) : c;
		dvd   = (DVD_W'(mag) << NORM_SH) + DVD_W'(len >> 1);
		r.rem = ROOT_W'(dvd[DVD_W-1:QUO_W]);
		r.low = dvd[QUO_W-1:0];
		r.quo = '0;
		return r;
	endfunction

	function automatic dv_t dv_step(input dv_t a, input logic [ROOT_W-1:0] len);
		dv_t r;
		logic [ROOT_W:0] t;
		t     = {a.rem, a.low[QUO_W-1]};
		r.low = a.low << 1;
		if (t >= {1'b0, len}) begin
			r.rem = ROOT_W'(t - {1'b0, len});
			r.quo = {a.quo[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = ROOT_W'(t);
			r.quo = {a.quo[QUO_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic val_t dv_fin(input logic [QUO_W-1:0] q, input logic neg, input logic zero);
		val_t r;
		if (zero)
			r = '0;
		else if (neg)
			r = (q > QUO_W'(32768)) ? ACC_MIN[VAL_W-1:0] : val_t'(~q + 1'b1);
		else
			r = (q > QUO_W'(32767)) ? ACC_MAX[VAL_W-1:0] : val_t'(q);
		return r;
	endfunction

	logic                    vld_sq_s  [0:NS];
	sq_t   [NVEC-1:0]        sq_s      [0:NS];
	vec3_t [NVEC-1:0]        vec_sq_s  [0:NS];
	logic  [NVEC-1:0]        zero_sq_s [0:NS];
	logic  [SIDE_W-1:0]      side_sq_s [0:NS];

	logic                    vld_dv_s  [0:ND];
	dv_t   [NVEC-1:0][2:0]   dv_s      [0:ND];
	logic  [NVEC-1:0][2:0]   neg_dv_s  [0:ND];
	logic  [NVEC-1:0][ROOT_W-1:0] len_dv_s [0:ND];
	logic  [NVEC-1:0]        zero_dv_s [0:ND];
	logic  [SIDE_W-1:0]      side_dv_s [0:ND];

	logic                    res_vld_s;
	vec3_t [NVEC-1:0]        res_vec_s;
	logic  [SIDE_W-1:0]      res_side_s;

	logic  [NVEC-1:0][LEN2_W-1:0] len2_c;

	always_comb begin
		for (int v = 0; v < NVEC; v++)
			len2_c[v] = sq_val(in_vec[v][0]) + sq_val(in_vec[v][1]) + sq_val(in_vec[v][2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++)
				vld_sq_s[k] <= 1'b0;
			for (int k = 0; k <= ND; k++)
				vld_dv_s[k] <= 1'b0;
			res_vld_s <= 1'b0;
		end else if (adv) begin
			vld_sq_s[0] <= in_vld;
			for (int k = 1; k <= NS; k++)
				vld_sq_s[k] <= vld_sq_s[k-1];
			vld_dv_s[0] <= vld_sq_s[NS];
			for (int k = 1; k <= ND; k++)
				vld_dv_s[k] <= vld_dv_s[k-1];
			res_vld_s <= vld_dv_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// squares
			for (int v = 0; v < NVEC; v++) begin
				sq_s[0][v].rem  <= '0;
				sq_s[0][v].root <= '0;
				sq_s[0][v].rad  <= len2_c[v];
				zero_sq_s[0][v] <= (len2_c[v] == '0);
			end
			vec_sq_s[0]  <= in_vec;
			side_sq_s[0] <= in_side;
			// square root, two root bits per stage
			for (int k = 1; k <= NS; k++) begin
				for (int v = 0; v < NVEC; v++)
					sq_s[k][v] <= sq_step(sq_step(sq_s[k-1][v]));
				vec_sq_s[k]  <= vec_sq_s[k-1];
				zero_sq_s[k] <= zero_sq_s[k-1];
				side_sq_s[k] <= side_sq_s[k-1];
			end
			// divide setup
			for (int v = 0; v < NVEC; v++) begin
				for (int i = 0; i < 3; i++) begin
					dv_s[0][v][i]     <= dv_init(vec_sq_s[NS][v][i], sq_s[NS][v].root);
					neg_dv_s[0][v][i] <= vec_sq_s[NS][v][i][VAL_W-1];
				end
				len_dv_s[0][v] <= sq_s[NS][v].root;
			end
			zero_dv_s[0] <= zero_sq_s[NS];
			side_dv_s[0] <= side_sq_s[NS];
			// divide, two quotient bits per stage
			for (int k = 1; k <= ND; k++) begin
				for (int v = 0; v < NVEC; v++)
					for (int i = 0; i < 3; i++)
						dv_s[k][v][i] <= dv_step(dv_step(dv_s[k-1][v][i], len_dv_s[k-1][v]),
							len_dv_s[k-1][v]);
				neg_dv_s[k]  <= neg_dv_s[k-1];
				len_dv_s[k]  <= len_dv_s[k-1];
				zero_dv_s[k] <= zero_dv_s[k-1];
				side_dv_s[k] <= side_dv_s[k-1];
			end
			for (int v = 0; v < NVEC; v++)
				for (int i = 0; i < 3; i++)
					res_vec_s[v][i] <= dv_fin(dv_s[ND][v][i].quo, neg_dv_s[ND][v][i],
						zero_dv_s[ND][v]);
			res_side_s <= side_dv_s[ND];
		end
	end

	assign out_vld  = res_vld_s;
	assign out_vec  = res_vec_s;
	assign out_side = res_side_s;

	// a normalized component never leaves the unit range by more than rounding
	generate
		for (genvar gv = 0; gv < NVEC; gv++) begin : g_chk
			for (genvar gi = 0; gi < 3; gi++) begin : g_comp
				a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
					res_vld_s |-> ($signed(res_vec_s[gv][gi]) <= UNIT_LIM &&
					$signed(res_vec_s[gv][gi]) >= -UNIT_LIM))
					else $error("normalized component out of unit range");
			end
		end
	endgenerate

endmodule

>>> tb/sv/tb.sv
// testbench for vertex_phong_lighting_top: random and directed vertices under
// bursty input and stalled output, checked against an in-bench lighting model
// depends on vpl_pkg and the block's rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vpl_pkg::*;

	typedef longint v3_t[3];

	class lit_vertex_board;
		logic [CFG_W-1:0] rows[7];
		logic [OUT_W-1:0] lit_q[$];
		int errors;

		function void set_row(reg_idx_t idx, logic [CFG_W-1:0] v);
			rows[idx] = (idx == REG_LIGHT) ? {16'h0, v[LIGHT_W-1:0]} : v;
		endfunction

		function longint lv(logic [CFG_W-1:0] r, int k);
			logic signed [15:0] s;
			s = r[16*k +: 16];
			return longint'(s);
		endfunction

		function longint sat(longint v);
			return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
		endfunction

		function longint rq(longint v);
			return (v + HALF_Q) >>> FRAC_BITS;
		endfunction

		function longint mq(longint a, longint b);
			return sat(rq(a * b));
		endfunction

		function longint isqrt(longint x);
			longint r, b;
			r = 0;
			b = 64'sh1 << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function v3_t unit(v3_t c);
			v3_t o;
			longint len2, len, num, mag, q;
			len2 = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
			o = '{0, 0, 0};
			if (len2 != 0) begin
				len = isqrt(len2 << 16);
				for (int i = 0; i < 3; i++) begin
					num = c[i] << NORM_SH;
					mag = num < 0 ? -num : num;
					q = (mag + len / 2) / len;
					o[i] = sat(num < 0 ? -q : q);
				end
			end
			return o;
		endfunction

		function void note(logic [IN_W-1:0] d);
			v3_t p, nin, cam, nc, n, l, vv, v, rr, r;
			longint dd, diff, rv, spec, inten;
			logic [7:0] shin;
			for (int i = 0; i < 3; i++) begin
				p[i] = lv({48'h0, d[IN_POS + 16*i +: 16]}, 0);
				nin[i] = lv({48'h0, d[IN_NRM + 16*i +: 16]}, 0);
				l[i] = lv(rows[REG_LIGHT], i);
			end
			shin = d[IN_SHIN +: 8];
			for (int i = 0; i < 3; i++) begin
				cam[i] = sat(rq(lv(rows[i], 0)*p[0] + lv(rows[i], 1)*p[1] +
					lv(rows[i], 2)*p[2] + lv(rows[i], 3)*ONE_Q));
				nc[i] = sat(rq(lv(rows[3+i], 0)*nin[0] + lv(rows[3+i], 1)*nin[1] +
					lv(rows[3+i], 2)*nin[2]));
				vv[i] = sat(-cam[i]);
			end
			n = unit(nc);
			v = unit(vv);
			dd = sat(rq(n[0]*l[0] + n[1]*l[1] + n[2]*l[2]));
			diff = dd > 0 ? dd : 0;
			for (int i = 0; i < 3; i++)
				rr[i] = sat(sat(rq(n[i] * 2 * dd)) - l[i]);
			r = unit(rr);
			rv = sat(rq(r[0]*v[0] + r[1]*v[1] + r[2]*v[2]));
			if (rv < 0)
				rv = 0;
			spec = ONE_Q;
			for (int b = EXP_BITS - 1; b >= 0; b--) begin
				spec = mq(spec, spec);
				if (shin[b])
					spec = mq(spec, rv);
			end
			inten = AMBIENT_Q + mq(KD_Q, diff) + mq(KS_Q, spec);
			if (inten > 32767)
				inten = 32767;
			if (inten < 0)
				inten = 0;
			lit_q.push_back({7'h0, cam[2][15:0], cam[1][15:0], cam[0][15:0],
				inten[14:0], d[1:0]});
		endfunction

		function void check(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] e;
			if (lit_q.size() == 0) begin
				$error("unexpected item %h", got);
				errors++;
				return;
			end
			e = lit_q.pop_front();
			if (got[1:0] !== e[1:0]) begin
				$error("corner_out exp %0d got %0d", e[1:0], got[1:0]);
				errors++;
			end
			if (got[16:2] !== e[16:2]) begin
				$error("intensity exp %0d got %0d", e[16:2], got[16:2]);
				errors++;
			end
			if (got[32:17] !== e[32:17]) begin
				$error("cam_x exp %0d got %0d", $signed(e[32:17]), $signed(got[32:17]));
				errors++;
			end
			if (got[48:33] !== e[48:33]) begin
				$error("cam_y exp %0d got %0d", $signed(e[48:33]), $signed(got[48:33]));
				errors++;
			end
			if (got[64:49] !== e[64:49]) begin
				$error("cam_z exp %0d got %0d", $signed(e[64:49]), $signed(got[64:49]));
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	lit_vertex_board sb;
	int stall_mode;
	int burst_left;
	longint cycles;

	vertex_phong_lighting_top u_top (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("vertex_phong_lighting_top: mismatch");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(3) != 0);
			2: m_tready <= ($urandom_range(3) == 0);
			default: m_tready <= (cycles % 7) < 4;
		endcase
	end

	task automatic send_vertex(logic [IN_W-1:0] d);
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note(d);
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(12);
			if ($urandom_range(2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [IN_W-1:0] pack_vertex(logic [1:0] c, logic [15:0] px,
		logic [15:0] py, logic [15:0] pz, logic [15:0] nx, logic [15:0] ny,
		logic [15:0] nz, logic [7:0] sh);
		return {6'h0, sh, nz, ny, nx, pz, py, px, c};
	endfunction

	function automatic logic [15:0] rval(bit narrow);
		return narrow ? 16'($signed($urandom_range(32768)) - 16384) : 16'($urandom);
	endfunction

	function automatic logic [IN_W-1:0] rand_vertex();
		bit nw;
		logic [7:0] sh;
		nw = $urandom_range(1);
		sh = $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom);
		return pack_vertex(2'($urandom), rval(nw), rval(nw), rval(nw),
			rval(nw), rval(nw), rval(nw), sh);
	endfunction

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.lit_q.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic write_rows(logic [CFG_W-1:0] v[7]);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IDX_W'(i);
			cfg_data <= v[i];
			sb.set_row(reg_idx_t'(i), v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_row(int kind);
		logic [CFG_W-1:0] r;
		for (int k = 0; k < 4; k++)
			case (kind)
				0: r[16*k +: 16] = 16'($signed($urandom_range(16384)) - 8192);
				1: r[16*k +: 16] = 16'($urandom);
				2: r[16*k +: 16] = 16'h7fff;
				default: r[16*k +: 16] = 16'h8000;
			endcase
		return r;
	endfunction

	task automatic run_random(int cnt);
		for (int i = 0; i < cnt; i++) begin
			if (i % 97 == 0)
				stall_mode = $urandom_range(3);
			send_vertex(rand_vertex());
		end
	endtask

	initial begin
		logic [CFG_W-1:0] v[7];
		sb = new();
		sb.rows = '{64'd16384, 64'd1073741824, 64'd70368744177664, 64'd16384,
			64'd1073741824, 64'd70368744177664, 64'd70368744177664};
		stall_mode = 0;
		burst_left = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners of the space under reset rows
		send_vertex(pack_vertex(2'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 8'd255));
		send_vertex(pack_vertex(2'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 8'd255));
		send_vertex(pack_vertex(2'd2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0));
		send_vertex(pack_vertex(2'd3, 16'h1000, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h0, 8'd7));
		send_vertex(pack_vertex(2'd0, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h4000, 8'd0));
		send_vertex(pack_vertex(2'd1, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h4000, 8'd1));
		send_vertex(pack_vertex(2'd2, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h4000,
			8'd128));
		send_vertex(pack_vertex(2'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hc000, 8'd0));
		send_vertex(pack_vertex(2'd0, 16'h2000, 16'h2000, 16'hc000, 16'h2d41, 16'h0,
			16'h2d41, 8'd16));
		send_vertex(pack_vertex(2'd1, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h7fff,
			16'h8000, 8'd255));
		send_vertex(pack_vertex(2'd2, 16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff,
			16'h0001, 8'd3));
		run_random(280);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 6; i++)
				v[i] = rand_row(ph < 2 ? 0 : (ph == 2 ? 1 : (ph == 3 ? 2 : (ph == 4 ? 3 : 0))));
			case (ph)
				3: v[REG_LIGHT] = {16'h0, 16'h7fff, 16'h7fff, 16'h7fff};
				4: v[REG_LIGHT] = {16'h0, 16'h8000, 16'h8000, 16'h8000};
				5: v[REG_LIGHT] = {$urandom, $urandom};
				default: v[REG_LIGHT] = {16'h0, 16'h2d41, 16'h0, 16'h2d41};
			endcase
			write_rows(v);
			send_vertex(pack_vertex(2'd3, 16'h7fff, 16'h8000, 16'h7fff, 16'h4000, 16'h0,
				16'h0, 8'd255));
			run_random(ph == 3 || ph == 4 ? 120 : 260);
			wait_idle();
		end

		if (sb.errors == 0 && sb.lit_q.size() == 0)
			$display("vertex_phong_lighting_top: match");
		else
			$display("vertex_phong_lighting_top: mismatch");
		$finish;
	end
endmodule

>>> vertex_phong_lighting_top.f
sv/vpl_pkg.sv
sv/vpl_norm.sv
sv/vertex_phong_lighting_top.sv
tb/sv/tb.sv
